[design/gost_block_cipher_modes_macros.svh]
// Assertion macros shared by the GOST block cipher modes core.
`ifndef GOST_BLOCK_CIPHER_MODES_MACROS_SVH
`define GOST_BLOCK_CIPHER_MODES_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GBCM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gbcm: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define GBCM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gbcm: next-cycle check failed");

`endif

[design/gbcm_pkg.sv]
`timescale 1ns / 1ps
// Package: S-box, counter gamma constants, register indexes and microcode ROM of the cipher core.
package gbcm_pkg;

    localparam int unsigned BLOCK_W      = 64;
    localparam int unsigned WORD_W       = 32;
    localparam int unsigned ROT_AMOUNT   = 11;
    localparam int unsigned ROUNDS_FULL  = 32;
    localparam int unsigned ROUNDS_SHORT = 8;
    localparam int unsigned RND_W        = $clog2(ROUNDS_FULL);
    localparam int unsigned KEY_WORDS    = 8;
    localparam int unsigned KEY_IDX_W    = $clog2(KEY_WORDS);
    localparam int unsigned CFG_IDX_W    = 3;

    localparam logic [WORD_W-1:0] GAMMA_ADD_LO = 32'h0101_0101;
    localparam logic [WORD_W-1:0] GAMMA_ADD_HI = 32'h0101_0104;
    localparam logic [WORD_W-1:0] GAMMA_WRAP   = 32'hFFFF_FFFF;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KEY_01 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_23 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_45 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_67 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC   = 3'd6;

    // Cipher modes
    localparam logic [1:0] MODE_PLAIN    = 2'd0;
    localparam logic [1:0] MODE_COUNTER  = 2'd1;
    localparam logic [1:0] MODE_FEEDBACK = 2'd2;

    // SBOX_ROWS[value][column]
    localparam logic [3:0] SBOX_ROWS [16][8] = '{
        '{ 4, 14,  5,  7,  6,  4, 13,  1},
        '{10, 11,  8, 13, 12, 11, 11, 15},
        '{ 9,  4,  1, 10,  7, 10,  4, 13},
        '{ 2, 12, 13,  1,  1,  0,  1,  0},
        '{13,  6, 10,  0,  5,  7,  3,  5},
        '{ 8, 13,  3,  8, 15,  2, 15,  7},
        '{ 0, 15,  4,  9, 13,  1,  5, 10},
        '{14, 10,  2, 15,  8, 13,  9,  4},
        '{ 6,  2, 14, 14,  4,  3,  0,  9},
        '{11,  3, 15,  4, 10,  6, 10,  2},
        '{ 1,  8, 12,  6,  9,  8, 14,  3},
        '{12,  1,  7, 12, 14,  5,  7, 14},
        '{ 7,  0,  6, 11,  0,  9,  6,  6},
        '{15,  7,  0,  2,  3, 12,  8, 11},
        '{ 5,  5,  9,  5, 11, 15,  2,  8},
        '{ 3,  9, 11,  3,  2, 14, 12, 12}
    };

    // Nibble i goes through S-box column i.
    function automatic logic [WORD_W-1:0] substitute(input logic [WORD_W-1:0] x);
        logic [WORD_W-1:0] r;
        r = '0;
        for (int i = 0; i < 8; i++) begin
            r[4*i +: 4] = SBOX_ROWS[x[4*i +: 4]][i];
        end
        return r;
    endfunction

    // Microcode
    localparam int unsigned UPC_W = 3;
    typedef logic [UPC_W-1:0] t_upc;

    typedef enum logic [2:0] {
        UOP_NOP,
        UOP_IDLE,
        UOP_LOAD,
        UOP_GAMMA,
        UOP_ROUND,
        UOP_FINISH
    } t_uop;

    typedef enum logic [2:0] {
        UC_ALWAYS,
        UC_NO_INPUT,
        UC_NOT_GAMMA,
        UC_MORE_ROUNDS,
        UC_OUT_BUSY
    } t_ucond;

    typedef struct packed {
        t_uop   op;
        t_ucond cond;
        t_upc   jt;   // taken when cond holds
        t_upc   jf;   // taken otherwise
    } t_uword;

    localparam t_upc UPC_IDLE   = 3'd0;
    localparam t_upc UPC_LOAD   = 3'd1;
    localparam t_upc UPC_GAMMA  = 3'd2;
    localparam t_upc UPC_ROUND  = 3'd3;
    localparam t_upc UPC_FINISH = 3'd4;

    function automatic t_uword ucode(input t_upc pc);
        t_uword w;
        unique case (pc)
            UPC_IDLE:   w = '{UOP_IDLE,   UC_NO_INPUT,    UPC_IDLE,   UPC_LOAD};
            UPC_LOAD:   w = '{UOP_LOAD,   UC_NOT_GAMMA,   UPC_ROUND,  UPC_GAMMA};
            UPC_GAMMA:  w = '{UOP_GAMMA,  UC_ALWAYS,      UPC_ROUND,  UPC_ROUND};
            UPC_ROUND:  w = '{UOP_ROUND,  UC_MORE_ROUNDS, UPC_ROUND,  UPC_FINISH};
            UPC_FINISH: w = '{UOP_FINISH, UC_OUT_BUSY,    UPC_FINISH, UPC_IDLE};
            default:    w = '{UOP_NOP,    UC_ALWAYS,      UPC_IDLE,   UPC_IDLE};
        endcase
        return w;
    endfunction

endpackage

[design/gbcm_round.sv]
`timescale 1ns / 1ps
// One Feistel round: key add, S-box substitution, rotate left, XOR, half swap.
module gbcm_round (
    input  logic [gbcm_pkg::BLOCK_W-1:0] i_block,
    input  logic [gbcm_pkg::WORD_W-1:0]  i_key,
    output logic [gbcm_pkg::BLOCK_W-1:0] o_block
);

    logic [gbcm_pkg::WORD_W-1:0] lo;
    logic [gbcm_pkg::WORD_W-1:0] hi;
    logic [gbcm_pkg::WORD_W-1:0] sub;
    logic [gbcm_pkg::WORD_W-1:0] rot;

    assign lo  = i_block[gbcm_pkg::WORD_W-1:0];
    assign hi  = i_block[gbcm_pkg::BLOCK_W-1:gbcm_pkg::WORD_W];
    assign sub = gbcm_pkg::substitute(lo + i_key);
    assign rot = {sub[gbcm_pkg::WORD_W-gbcm_pkg::ROT_AMOUNT-1:0],
                  sub[gbcm_pkg::WORD_W-1:gbcm_pkg::WORD_W-gbcm_pkg::ROT_AMOUNT]};

    // Old low half moves up, round result becomes the new low half.
    assign o_block = {lo, rot ^ hi};

endmodule

[design/gost_block_cipher_modes.sv]
`timescale 1ns / 1ps
// Top level: GOST 28147-89 cipher core with plain, counter gamma and feedback gamma modes.
//
// Input channel (i_in_valid / o_in_ready) takes one 64-bit item with its encrypt and
// start-of-message flags; output channel (o_out_valid / i_out_ready) returns one
// 64-bit result per item. o_in_ready is high only while the sequencer sits idle.
// Configuration is a plain write port (i_cfg_wr_en, i_cfg_index, i_cfg_data), to be
// used only while no item is in flight. Index 7 is ignored.
// A microcode ROM steps the datapath: load, gamma update (counter mode only), one
// Feistel round per cycle, then a finish step that writes the output register.
// The shared round unit runs 32 rounds with the full key or 8 with the short key, one
// after another, and no new item is taken until the sequencer has returned to idle.
// The output register holds its result while i_out_ready is low; the finish step
// waits until it is free, and no new item is taken meanwhile.
// Reset (synchronous, active low) zeroes keys, sync value and chain, selects
// feedback mode with the full key, and drops any pending result.
`include "gost_block_cipher_modes_macros.svh"
module gost_block_cipher_modes (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [gbcm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [gbcm_pkg::BLOCK_W-1:0]        i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [gbcm_pkg::BLOCK_W-1:0]        i_data_block,
    input  logic                                i_encrypt,
    input  logic                                i_start_of_message,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [gbcm_pkg::BLOCK_W-1:0]        o_result_block
);

    localparam int unsigned W = gbcm_pkg::WORD_W;
    localparam int unsigned B = gbcm_pkg::BLOCK_W;

    // Configuration
    logic [W-1:0] r_key [gbcm_pkg::KEY_WORDS];
    logic [1:0]   r_mode;
    logic         r_short;
    logic [B-1:0] r_sync;

    // Sequencer and datapath
    gbcm_pkg::t_upc           r_pc;
    gbcm_pkg::t_upc           n_pc;
    gbcm_pkg::t_uword         uw;
    logic [gbcm_pkg::RND_W-1:0] r_rnd;
    logic [B-1:0]             r_n;
    logic [B-1:0]             r_data;
    logic                     r_enc;
    logic                     r_dir;
    logic [B-1:0]             r_chain;
    logic [B-1:0]             r_result;
    logic                     r_out_valid;

    logic                     in_acc;
    logic                     out_busy;
    logic                     fin_fire;
    logic                     in_round;
    logic                     at_idle;
    logic                     short_rnd_ok;
    logic                     last_rnd;
    logic                     cond_hit;
    logic [1:0]               phase;
    logic                     fwd;
    logic [gbcm_pkg::KEY_IDX_W-1:0] pos;
    logic [gbcm_pkg::KEY_IDX_W-1:0] key_idx;
    logic [B-1:0]             round_out;
    logic [W-1:0]             g_lo;
    logic [W-1:0]             g_hi_sum;
    logic [W-1:0]             g_hi;
    logic [B-1:0]             enc_out;
    logic [B-1:0]             xored;
    logic [B-1:0]             fin_result;
    logic [B-1:0]             fin_chain;
    logic                     fin_chain_we;

    assign uw         = gbcm_pkg::ucode(r_pc);
    assign o_in_ready = (uw.op == gbcm_pkg::UOP_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign out_busy   = r_out_valid && !i_out_ready;
    assign fin_fire   = (uw.op == gbcm_pkg::UOP_FINISH) && !out_busy;
    assign in_round   = (uw.op == gbcm_pkg::UOP_ROUND);
    assign at_idle    = (r_pc == gbcm_pkg::UPC_IDLE);
    assign short_rnd_ok   = (r_rnd <= gbcm_pkg::RND_W'(gbcm_pkg::ROUNDS_SHORT - 1));
    assign o_out_valid    = r_out_valid;
    assign o_result_block = r_result;

    assign last_rnd = r_short ? (r_rnd == gbcm_pkg::RND_W'(gbcm_pkg::ROUNDS_SHORT - 1))
                              : (r_rnd == gbcm_pkg::RND_W'(gbcm_pkg::ROUNDS_FULL - 1));

    // Key schedule: four passes, each forward or backward over the key words.
    assign phase = r_short ? r_rnd[2:1] : r_rnd[4:3];
    assign fwd   = r_dir ? (phase != 2'd3) : (phase == 2'd0);
    assign pos   = r_short ? {2'b00, r_rnd[0]} : r_rnd[2:0];
    assign key_idx = fwd ? pos : (r_short ? {2'b00, ~r_rnd[0]} : ~r_rnd[2:0]);

    gbcm_round u_round (
        .i_block (r_n),
        .i_key   (r_key[key_idx]),
        .o_block (round_out)
    );

    // Counter gamma step on the chain
    assign g_lo     = r_chain[W-1:0] + gbcm_pkg::GAMMA_ADD_LO;
    assign g_hi_sum = r_chain[B-1:W] + gbcm_pkg::GAMMA_ADD_HI;
    assign g_hi     = (g_hi_sum == gbcm_pkg::GAMMA_WRAP) ? '0 : g_hi_sum;

    // Final half swap and mode-specific output
    assign enc_out = {r_n[W-1:0], r_n[B-1:W]};
    assign xored   = r_data ^ enc_out;

    always_comb begin
        fin_result   = '0;
        fin_chain    = r_chain;
        fin_chain_we = 1'b0;
        unique case (r_mode)
            gbcm_pkg::MODE_PLAIN: begin
                fin_result = enc_out;
            end
            gbcm_pkg::MODE_COUNTER: begin
                fin_result   = xored;
                fin_chain    = enc_out;
                fin_chain_we = 1'b1;
            end
            gbcm_pkg::MODE_FEEDBACK: begin
                fin_result   = xored;
                fin_chain    = r_enc ? xored : r_data;
                fin_chain_we = 1'b1;
            end
            default: begin
                // unused mode: zero result, chain held
                fin_result = '0;
            end
        endcase
    end

    always_comb begin
        unique case (uw.cond)
            gbcm_pkg::UC_ALWAYS:      cond_hit = 1'b1;
            gbcm_pkg::UC_NO_INPUT:    cond_hit = !i_in_valid;
            gbcm_pkg::UC_NOT_GAMMA:   cond_hit = (r_mode != gbcm_pkg::MODE_COUNTER);
            gbcm_pkg::UC_MORE_ROUNDS: cond_hit = !last_rnd;
            gbcm_pkg::UC_OUT_BUSY:    cond_hit = out_busy;
            default:                  cond_hit = 1'b1;
        endcase
        n_pc = cond_hit ? uw.jt : uw.jf;
    end

    // Control, configuration and chain state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= gbcm_pkg::UPC_IDLE;
            r_rnd       <= '0;
            r_out_valid <= 1'b0;
            r_mode      <= gbcm_pkg::MODE_FEEDBACK;
            r_short     <= 1'b0;
            r_sync      <= '0;
            r_chain     <= '0;
            for (int i = 0; i < gbcm_pkg::KEY_WORDS; i++) begin
                r_key[i] <= '0;
            end
        end else begin
            r_pc <= n_pc;

            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    gbcm_pkg::REG_KEY_01: begin
                        r_key[0] <= i_cfg_data[W-1:0];
                        r_key[1] <= i_cfg_data[B-1:W];
                    end
                    gbcm_pkg::REG_KEY_23: begin
                        r_key[2] <= i_cfg_data[W-1:0];
                        r_key[3] <= i_cfg_data[B-1:W];
                    end
                    gbcm_pkg::REG_KEY_45: begin
                        r_key[4] <= i_cfg_data[W-1:0];
                        r_key[5] <= i_cfg_data[B-1:W];
                    end
                    gbcm_pkg::REG_KEY_67: begin
                        r_key[6] <= i_cfg_data[W-1:0];
                        r_key[7] <= i_cfg_data[B-1:W];
                    end
                    gbcm_pkg::REG_MODE:  r_mode  <= i_cfg_data[1:0];
                    gbcm_pkg::REG_SHORT: r_short <= i_cfg_data[0];
                    gbcm_pkg::REG_SYNC:  r_sync  <= i_cfg_data;
                    default: begin
                        // drop writes beyond the register list
                    end
                endcase
            end

            if (fin_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (uw.op)
                gbcm_pkg::UOP_IDLE: begin
                    if (in_acc && i_start_of_message) begin
                        r_chain <= r_sync;
                    end
                end
                gbcm_pkg::UOP_LOAD: begin
                    r_rnd <= '0;
                end
                gbcm_pkg::UOP_ROUND: begin
                    if (!last_rnd) begin
                        r_rnd <= r_rnd + 1'b1;
                    end
                end
                gbcm_pkg::UOP_FINISH: begin
                    if (fin_fire && fin_chain_we) begin
                        r_chain <= fin_chain;
                    end
                end
                default: begin
                    // nothing to do
                end
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_data <= i_data_block;
            r_enc  <= i_encrypt;
            r_dir  <= (r_mode != gbcm_pkg::MODE_PLAIN) || i_encrypt;
        end
        unique case (uw.op)
            gbcm_pkg::UOP_LOAD: begin
                r_n <= (r_mode == gbcm_pkg::MODE_PLAIN) ? r_data : r_chain;
            end
            gbcm_pkg::UOP_GAMMA: begin
                r_n <= {g_hi, g_lo};
            end
            gbcm_pkg::UOP_ROUND: begin
                r_n <= round_out;
            end
            gbcm_pkg::UOP_FINISH: begin
                if (fin_fire) begin
                    r_result <= fin_result;
                end
            end
            default: begin
                // hold
            end
        endcase
    end

    `GBCM_ASSERT_NEXT(a_accept_loads, i_clk, i_rst_n, in_acc, r_pc == gbcm_pkg::UPC_LOAD)
    `GBCM_ASSERT_SAME(a_short_round_bound, i_clk, i_rst_n, in_round && r_short, short_rnd_ok)
    `GBCM_ASSERT_NEXT(a_finish_emits, i_clk, i_rst_n, fin_fire, r_out_valid && at_idle)

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for the GOST block cipher modes core: modes, key lengths, handshakes.
module tb;

    localparam int WATCHDOG_LIMIT   = 5000;
    localparam int HOLD_CYCLES      = 300;
    localparam int PHASES           = 12;
    localparam int BLOCKS_PER_PHASE = 128;

    localparam logic [gbcm_pkg::CFG_IDX_W-1:0] REG_UNUSED  = 3'd7;
    localparam logic [1:0]                     MODE_UNUSED = 2'd3;

    localparam bit [31:0] CTR_STEP_LO = 32'h0101_0101;
    localparam bit [31:0] CTR_STEP_HI = 32'h0101_0104;
    localparam bit [31:0] CTR_SKIP    = 32'hFFFF_FFFF;

    // GOST_SBOX[value][column]
    localparam bit [3:0] GOST_SBOX [16][8] = '{
        '{ 4, 14,  5,  7,  6,  4, 13,  1},
        '{10, 11,  8, 13, 12, 11, 11, 15},
        '{ 9,  4,  1, 10,  7, 10,  4, 13},
        '{ 2, 12, 13,  1,  1,  0,  1,  0},
        '{13,  6, 10,  0,  5,  7,  3,  5},
        '{ 8, 13,  3,  8, 15,  2, 15,  7},
        '{ 0, 15,  4,  9, 13,  1,  5, 10},
        '{14, 10,  2, 15,  8, 13,  9,  4},
        '{ 6,  2, 14, 14,  4,  3,  0,  9},
        '{11,  3, 15,  4, 10,  6, 10,  2},
        '{ 1,  8, 12,  6,  9,  8, 14,  3},
        '{12,  1,  7, 12, 14,  5,  7, 14},
        '{ 7,  0,  6, 11,  0,  9,  6,  6},
        '{15,  7,  0,  2,  3, 12,  8, 11},
        '{ 5,  5,  9,  5, 11, 15,  2,  8},
        '{ 3,  9, 11,  3,  2, 14, 12, 12}
    };

    class cipher_scoreboard;
        bit [31:0] key_word [8];
        bit [1:0]  mode;
        bit        short_key;
        bit [63:0] sync_value;
        bit [63:0] chain;
        bit [63:0] expected_blocks [$];
        int        mismatches;
        int        results_seen;

        function new();
            mode = gbcm_pkg::MODE_FEEDBACK;
        endfunction

        function void set_reg(logic [gbcm_pkg::CFG_IDX_W-1:0] idx, bit [63:0] value);
            case (idx)
                gbcm_pkg::REG_KEY_01, gbcm_pkg::REG_KEY_23,
                gbcm_pkg::REG_KEY_45, gbcm_pkg::REG_KEY_67: begin
                    key_word[2 * idx]     = value[31:0];
                    key_word[2 * idx + 1] = value[63:32];
                end
                gbcm_pkg::REG_MODE:  mode = value[1:0];
                gbcm_pkg::REG_SHORT: short_key = value[0];
                gbcm_pkg::REG_SYNC:  sync_value = value;
                default: ;
            endcase
        endfunction

        function bit [63:0] cipher_block(bit [63:0] n, bit enc);
            int unsigned w;
            int unsigned j;
            bit [31:0]   s;
            w = short_key ? 2 : 8;
            for (int unsigned r = 0; r < 4 * w; r++) begin
                // forward key order for three passes on encrypt, for one on decrypt
                if (enc ? (r < 3 * w) : (r < w)) j = r % w;
                else j = w - 1 - r % w;
                s = n[31:0] + key_word[j];
                for (int i = 0; i < 8; i++) s[4*i +: 4] = GOST_SBOX[s[4*i +: 4]][i];
                s = {s[20:0], s[31:21]} ^ n[63:32];
                n = {n[31:0], s};
            end
            return {n[31:0], n[63:32]};
        endfunction

        function void note_block(bit [63:0] data, bit enc, bit som);
            bit [63:0] res;
            bit [31:0] lo;
            bit [31:0] hi;
            if (som) chain = sync_value;
            case (mode)
                gbcm_pkg::MODE_PLAIN: res = cipher_block(data, enc);
                gbcm_pkg::MODE_COUNTER: begin
                    lo = chain[31:0] + CTR_STEP_LO;
                    hi = chain[63:32] + CTR_STEP_HI;
                    if (hi == CTR_SKIP) hi = '0;
                    chain = cipher_block({hi, lo}, 1'b1);
                    res = data ^ chain;
                end
                gbcm_pkg::MODE_FEEDBACK: begin
                    res = data ^ cipher_block(chain, 1'b1);
                    chain = enc ? res : data;
                end
                default: res = '0;
            endcase
            expected_blocks.push_back(res);
        endfunction

        function void check_block(logic [63:0] actual);
            bit [63:0] want;
            results_seen++;
            if (expected_blocks.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d: got %h with no block pending", results_seen, actual);
            end else begin
                want = expected_blocks.pop_front();
                if (actual !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d: expected %h got %h", results_seen, want, actual);
                end
            end
        endfunction

        function int pending();
            return expected_blocks.size();
        endfunction
    endclass

    logic                           i_clk              = 1'b0;
    logic                           i_rst_n            = 1'b0;
    logic                           i_cfg_wr_en        = 1'b0;
    logic [gbcm_pkg::CFG_IDX_W-1:0] i_cfg_index        = '0;
    logic [63:0]                    i_cfg_data         = '0;
    logic                           i_in_valid         = 1'b0;
    logic                           o_in_ready;
    logic [63:0]                    i_data_block       = '0;
    logic                           i_encrypt          = 1'b0;
    logic                           i_start_of_message = 1'b0;
    logic                           o_out_valid;
    logic                           i_out_ready        = 1'b0;
    logic [63:0]                    o_result_block;

    cipher_scoreboard sb = new();
    int in_idle_pct   = 0;
    int out_stall_pct = 0;
    int quiet_cycles  = 0;
    int hold_left     = 0;
    bit hold_req      = 1'b0;

    gost_block_cipher_modes i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_wr_en        (i_cfg_wr_en),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_data_block       (i_data_block),
        .i_encrypt          (i_encrypt),
        .i_start_of_message (i_start_of_message),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_result_block     (o_result_block)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Receiver: random stalls, plus a long hold-off on request.
    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= out_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready)
            sb.note_block(i_data_block, i_encrypt, i_start_of_message);
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready)
            sb.check_block(o_result_block);
        if ((i_in_valid && o_in_ready) || (o_out_valid === 1'b1 && i_out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
    end

    initial begin
        while (quiet_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic bit [63:0] rand_block();
        case ($urandom_range(15))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic bit [63:0] key_for_phase(int p);
        if (p == 1) return '1;
        if (p == 2) return '0;
        return rand_block();
    endfunction

    task automatic write_reg(input logic [gbcm_pkg::CFG_IDX_W-1:0] idx,
                             input bit [63:0] value);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        sb.set_reg(idx, value);
        @(posedge i_clk);
    endtask

    task automatic load_settings(input bit [63:0] k01, input bit [63:0] k23,
                                 input bit [63:0] k45, input bit [63:0] k67,
                                 input logic [1:0] mode, input bit sk, input bit [63:0] sync);
        write_reg(gbcm_pkg::REG_KEY_01, k01);
        write_reg(gbcm_pkg::REG_KEY_23, k23);
        write_reg(gbcm_pkg::REG_KEY_45, k45);
        write_reg(gbcm_pkg::REG_KEY_67, k67);
        write_reg(gbcm_pkg::REG_MODE, {62'd0, mode});
        write_reg(gbcm_pkg::REG_SHORT, {63'd0, sk});
        write_reg(gbcm_pkg::REG_SYNC, sync);
        // index 7 decodes to nothing; the write must not disturb the rest
        write_reg(REG_UNUSED, rand_block());
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic send_block(input bit [63:0] data, input bit enc, input bit som);
        if ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(40, 1)) @(posedge i_clk);
        end
        i_in_valid         <= 1'b1;
        i_data_block       <= data;
        i_encrypt          <= enc;
        i_start_of_message <= som;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        logic [1:0] mode_sel;
        bit         som;
        bit         enc;
        bit         msg_enc;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: feedback mode, zero keys, zero sync, zero chain
        send_block('0, 1'b1, 1'b0);
        send_block('1, 1'b0, 1'b1);
        drain();

        load_settings('1, '1, '1, '1, gbcm_pkg::MODE_PLAIN, 1'b0, '0);
        send_block('0, 1'b1, 1'b0);
        send_block('1, 1'b1, 1'b0);
        send_block('1, 1'b0, 1'b1);
        send_block('0, 1'b0, 1'b0);
        drain();

        load_settings(rand_block(), rand_block(), rand_block(), rand_block(),
                      gbcm_pkg::MODE_PLAIN, 1'b1, rand_block());
        send_block(rand_block(), 1'b1, 1'b0);
        send_block(rand_block(), 1'b0, 1'b1);
        drain();

        // counter start where the low word wraps and the high word lands on the skip value
        load_settings(rand_block(), rand_block(), rand_block(), rand_block(),
                      gbcm_pkg::MODE_COUNTER, 1'b0, 64'hFEFE_FEFB_FEFE_FEFF);
        send_block('0, 1'b1, 1'b1);
        send_block(rand_block(), 1'b1, 1'b0);
        send_block(rand_block(), 1'b0, 1'b0);
        send_block('1, 1'b0, 1'b1);
        drain();

        // unused mode: zero result, chain untouched
        load_settings(rand_block(), rand_block(), rand_block(), rand_block(),
                      MODE_UNUSED, 1'b0, rand_block());
        send_block(rand_block(), 1'b1, 1'b0);
        send_block(rand_block(), 1'b0, 1'b1);
        drain();

        load_settings(rand_block(), rand_block(), rand_block(), rand_block(),
                      gbcm_pkg::MODE_FEEDBACK, 1'b1, rand_block());
        send_block(rand_block(), 1'b1, 1'b0);
        send_block(rand_block(), 1'b0, 1'b0);
        drain();

        for (int p = 0; p < PHASES; p++) begin
            case (p % 4)
                0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
                1: begin in_idle_pct = 70; out_stall_pct = 0;  end
                2: begin in_idle_pct = 0;  out_stall_pct = 70; end
                default: begin in_idle_pct = 10; out_stall_pct = 10; end
            endcase
            mode_sel = (p % 3 == 0) ? gbcm_pkg::MODE_PLAIN :
                       (p % 3 == 1) ? gbcm_pkg::MODE_COUNTER : gbcm_pkg::MODE_FEEDBACK;
            load_settings(key_for_phase(p), key_for_phase(p), key_for_phase(p),
                          key_for_phase(p), mode_sel, ((p / 3) % 2) == 1,
                          (p % 5 == 0) ? '1 : (p % 5 == 1) ? '0 : rand_block());
            msg_enc = 1'b1;
            for (int k = 0; k < BLOCKS_PER_PHASE; k++) begin
                // messages keep one direction, with an occasional stray block
                som = (k == 0) || ($urandom_range(7) == 0);
                if (som) msg_enc = $urandom_range(1);
                enc = ($urandom_range(15) == 0) ? ~msg_enc : msg_enc;
                if (p % 4 == 0 && k == 5) hold_req = 1'b1;
                send_block(rand_block(), enc, som);
            end
            drain();
        end

        repeat (40) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

[files.f]
+incdir+design
design/gbcm_pkg.sv
design/gbcm_round.sv
design/gost_block_cipher_modes.sv
tb/tb.sv
